### src/kuf_pkg.sv
// ----------------------------------------------------------------------------
// kuf_pkg: shared types and constants for the union-find tree builder
// Holds memory sizes, field widths, the controller command set and status.
// ----------------------------------------------------------------------------
package kuf_pkg;

	localparam int MAX_PIXELS = 4096;
	localparam int PIX_W      = $clog2(MAX_PIXELS);
	localparam int NODE_W     = 13;
	localparam int ORDER_W    = 12;
	localparam int RANK_W     = 4;
	localparam int CFG_W      = 13;

	localparam logic [RANK_W-1:0] RANK_MAX = '1;

	localparam logic [0:0] KIND_START = 1'b0;
	localparam logic [0:0] KIND_EDGE  = 1'b1;

	localparam logic [0:0] REG_IMAGE_WIDTH = 1'b0;
	localparam logic [0:0] REG_PIXEL_COUNT = 1'b1;

	// Datapath operations issued by the controller
	localparam logic [2:0] OP_NONE   = 3'd0;
	localparam logic [2:0] OP_CLEAR  = 3'd1;
	localparam logic [2:0] OP_LOAD   = 3'd2;
	localparam logic [2:0] OP_RD     = 3'd3;
	localparam logic [2:0] OP_WALK   = 3'd4;
	localparam logic [2:0] OP_COMP   = 3'd5;
	localparam logic [2:0] OP_MERGE  = 3'd6;
	localparam logic [2:0] OP_RESULT = 3'd7;

	typedef struct packed {
		logic [2:0] op;
		logic       sel_y;   // work on the second pixel
		logic       bad;     // result is an out-of-range edge
		logic       start;   // result of a start item
	} kuf_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic is_root;       // registered parent read equals its address
		logic bad;           // decoded pixel out of range
		logic same;          // both roots equal
	} kuf_stat_t;

endpackage

### src/kuf_datapath.sv
// ----------------------------------------------------------------------------
// kuf_datapath: union-find memories, decode, root walk and merge logic
// One parent/rank/region memory row per pixel. After reset and on a start
// item a clearing pass rewrites one row per cycle as a fresh root. Memories
// read with registered data.
// ----------------------------------------------------------------------------
module kuf_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  kuf_pkg::kuf_cmd_t            cmd,
	output kuf_pkg::kuf_stat_t           stat,
	input  logic [kuf_pkg::NODE_W-1:0]   edge_code,
	input  logic [kuf_pkg::CFG_W-1:0]    image_width,
	input  logic [kuf_pkg::CFG_W-1:0]    pixel_count,
	output logic [kuf_pkg::NODE_W-1:0]   res_new_node,
	output logic [kuf_pkg::NODE_W-1:0]   res_child_first,
	output logic [kuf_pkg::NODE_W-1:0]   res_child_second,
	output logic [kuf_pkg::ORDER_W-1:0]  res_merge_order,
	output logic                         res_merged,
	output logic                         res_bad
);
	import kuf_pkg::*;

	localparam int ROW_W = PIX_W + RANK_W + NODE_W;

	// Row: parent, rank, region node
	logic [ROW_W-1:0]   mem [MAX_PIXELS];
	logic [ROW_W-1:0]   rd_q;
	logic [PIX_W-1:0]   rd_addr_q;
	logic [PIX_W:0]     clr_cnt_q;
	logic [PIX_W-1:0]   px_q, py_q, cur_q, root_x_q, root_y_q;
	logic [NODE_W-1:0]  next_node_q, tx_q;
	logic [RANK_W-1:0]  rank_x_q;
	logic [ORDER_W-1:0] acc_q;
	logic               bad_q;

	logic               wr_en;
	logic [PIX_W-1:0]   wr_addr, rd_addr;
	logic [ROW_W-1:0]   wr_data;
	logic [PIX_W-1:0]   rd_parent;
	logic [RANK_W-1:0]  rd_rank;
	logic [NODE_W-1:0]  rd_node;
	logic [CFG_W:0]     n_eff, px_w, py_w;
	logic [PIX_W-1:0]   lo, hi;
	logic [RANK_W-1:0]  rank_lo, rank_hi;
	logic               do_merge;

	assign n_eff = (pixel_count < CFG_W'(MAX_PIXELS)) ? {1'b0, pixel_count}
		: (CFG_W+1)'(MAX_PIXELS);
	assign px_w  = (CFG_W+1)'(edge_code >> 1);
	assign py_w  = edge_code[0] ? px_w + {1'b0, image_width} : px_w + 1'b1;

	// Split the registered row into its fields
	assign rd_parent = rd_q[ROW_W-1 -: PIX_W];
	assign rd_rank   = rd_q[RANK_W+NODE_W-1 -: RANK_W];
	assign rd_node   = rd_q[NODE_W-1:0];

	assign stat.clear_done = clr_cnt_q[PIX_W];
	assign stat.is_root    = rd_parent == rd_addr_q;
	assign stat.bad        = bad_q;
	assign stat.same       = root_x_q == root_y_q;

	// Only an in-range edge over two distinct roots merges
	assign do_merge = !cmd.bad && !cmd.start && !stat.same;

	// Merge by rank: lower rank points at higher
	always_comb begin
		if (rank_x_q > rd_rank) begin
			lo = root_y_q; hi = root_x_q; rank_lo = rd_rank; rank_hi = rank_x_q;
		end else begin
			lo = root_x_q; hi = root_y_q; rank_lo = rank_x_q; rank_hi = rd_rank;
		end
	end

	// Choose memory port addresses and write data per operation
	always_comb begin
		rd_addr = cur_q;
		wr_en   = 1'b0;
		wr_addr = cur_q;
		wr_data = '0;
		case (cmd.op)
			OP_LOAD: rd_addr = px_w[PIX_W-1:0];
			OP_RD:   rd_addr = cmd.sel_y ? py_q : px_q;
			OP_WALK: rd_addr = rd_parent;
			OP_COMP: begin
				// write parent of cur to root, step to old parent
				rd_addr = rd_parent;
				wr_en   = !stat.is_root;
				wr_addr = rd_addr_q;
				wr_data = {(cmd.sel_y ? root_y_q : root_x_q), rd_rank, rd_node};
			end
			OP_MERGE: begin
				// second root row is in rd_q
				wr_en   = 1'b1;
				wr_addr = lo;
				wr_data = {hi, rank_lo, (lo == root_x_q) ? tx_q : rd_node};
			end
			OP_RESULT: begin
				wr_en   = do_merge;
				wr_addr = cur_q;
				wr_data = {cur_q, rank_x_q, next_node_q};
			end
			default: ;
		endcase
		// the clearing pass owns the write port while it runs
		if (!clr_cnt_q[PIX_W]) begin
			wr_en   = 1'b1;
			wr_addr = clr_cnt_q[PIX_W-1:0];
			wr_data = {clr_cnt_q[PIX_W-1:0], {RANK_W{1'b0}},
				NODE_W'(clr_cnt_q[PIX_W-1:0])};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_q      <= mem[rd_addr];
		rd_addr_q <= rd_addr;
	end

	// Sequence registers for the walk and the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q   <= '0;
			next_node_q <= NODE_W'(MAX_PIXELS);
			acc_q       <= '0;
			res_merged  <= 1'b0;
			res_bad     <= 1'b0;
		end else begin
			// restart or advance the clearing pass
			if (cmd.op == OP_CLEAR)
				clr_cnt_q <= '0;
			else if (!clr_cnt_q[PIX_W])
				clr_cnt_q <= clr_cnt_q + 1'b1;
			case (cmd.op)
				OP_CLEAR: begin
					next_node_q <= NODE_W'(n_eff);
					acc_q       <= '0;
				end
				OP_LOAD: begin
					bad_q <= (px_w >= n_eff) || (py_w >= n_eff);
					px_q  <= px_w[PIX_W-1:0];
					py_q  <= py_w[PIX_W-1:0];
					cur_q <= px_w[PIX_W-1:0];
				end
				OP_RD: cur_q <= cmd.sel_y ? py_q : px_q;
				OP_WALK: begin
					// hold the root once the row points at itself
					if (stat.is_root) begin
						if (cmd.sel_y) begin
							root_y_q <= rd_addr_q;
						end else begin
							root_x_q <= rd_addr_q;
							rank_x_q <= rd_rank;
							tx_q     <= rd_node;
						end
					end
				end
				OP_COMP: cur_q <= rd_parent;
				OP_MERGE: begin
					// keep hi and its rank update for the result cycle
					cur_q    <= hi;
					rank_x_q <= (rank_lo == rank_hi && rank_hi != RANK_MAX)
						? rank_hi + 1'b1 : rank_hi;
					res_child_second <= rd_node;
				end
				OP_RESULT: begin
					res_merged <= do_merge;
					res_bad    <= cmd.bad;
					if (do_merge) begin
						res_new_node    <= next_node_q;
						res_child_first <= tx_q;
						res_merge_order <= acc_q;
						next_node_q     <= next_node_q + 1'b1;
						acc_q           <= acc_q + 1'b1;
					end else begin
						res_new_node     <= '0;
						res_child_first  <= '0;
						res_child_second <= '0;
						res_merge_order  <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// The result row write in OP_RESULT keeps hi as its own root
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_RESULT && do_merge |=> res_merged)
		else $error("merge result not flagged");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_RESULT && do_merge |=>
		next_node_q == $past(next_node_q) + 1'b1)
		else $error("node counter did not advance");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_CLEAR |=> !stat.clear_done)
		else $error("clearing pass not started");
endmodule

### src/kuf_ctrl.sv
// ----------------------------------------------------------------------------
// kuf_ctrl: controller for decode, two root walks with compression, merge
// Sequences the datapath and runs the input and output handshakes.
// ----------------------------------------------------------------------------
module kuf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_fire,
	input  logic                in_kind,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output kuf_pkg::kuf_cmd_t   cmd,
	input  kuf_pkg::kuf_stat_t  stat
);
	import kuf_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DEC   = 4'd1;
	localparam logic [3:0] S_RD    = 4'd2;
	localparam logic [3:0] S_WALK  = 4'd3;
	localparam logic [3:0] S_RD2   = 4'd4;
	localparam logic [3:0] S_COMP  = 4'd5;
	localparam logic [3:0] S_RDR   = 4'd6;
	localparam logic [3:0] S_MERGE = 4'd7;
	localparam logic [3:0] S_RES   = 4'd8;
	localparam logic [3:0] S_OUT   = 4'd9;
	localparam logic [3:0] S_START = 4'd10;
	localparam logic [3:0] S_RDY   = 4'd11;

	logic [3:0] state_q;
	logic       sel_y_q, bad_q;

	// Hold the input closed while the clearing pass runs
	assign in_ready  = state_q == S_IDLE && stat.clear_done;
	assign out_valid = state_q == S_OUT;

	// Issue one command per state
	always_comb begin
		cmd = '{op: OP_NONE, sel_y: sel_y_q, bad: 1'b0, start: 1'b0};
		case (state_q)
			S_IDLE:  if (in_fire && in_kind == KIND_EDGE) cmd.op = OP_LOAD;
				else if (in_fire) cmd.op = OP_CLEAR;
			S_RD:    cmd.op = OP_RD;
			S_WALK:  cmd.op = OP_WALK;
			S_RD2:   cmd.op = OP_RD;
			S_COMP:  cmd.op = OP_COMP;
			// read the second root row, left at cur by the compression
			S_RDY:   cmd.op = OP_NONE;
			S_MERGE: cmd.op = OP_MERGE;
			S_RES:   begin cmd.op = OP_RESULT; cmd.bad = bad_q; end
			S_START: begin
				cmd.op    = stat.clear_done ? OP_RESULT : OP_NONE;
				cmd.start = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sel_y_q <= 1'b0;
			bad_q   <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (in_fire) begin
					sel_y_q <= 1'b0;
					state_q <= (in_kind == KIND_EDGE) ? S_DEC : S_START;
				end
				S_DEC: begin
					bad_q   <= stat.bad;
					state_q <= stat.bad ? S_RES : S_RD;
				end
				S_RD:   state_q <= S_WALK;
				S_WALK: if (stat.is_root) state_q <= S_RDR;
				S_RDR:  state_q <= S_RD2;
				S_RD2:  state_q <= S_COMP;
				S_COMP: if (stat.is_root) begin
					if (sel_y_q) begin
						state_q <= stat.same ? S_RES : S_RDY;
						bad_q   <= 1'b0;
					end else begin
						sel_y_q <= 1'b1;
						state_q <= S_RD;
					end
				end
				S_RDY:   state_q <= S_MERGE;
				S_MERGE: state_q <= S_RES;
				S_RES:   state_q <= S_OUT;
				S_START: if (stat.clear_done) state_q <= S_OUT;
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) !(in_ready && out_valid))
		else $error("input open while result pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped");
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready)
		else $error("second request taken");
endmodule

### src/kruskal_union_find_tree_builder.sv
// ----------------------------------------------------------------------------
// kruskal_union_find_tree_builder: union-find partition tree over grid edges
//
//  channel | dir | contents
//  s_axis  | in  | tuser kind, tdata edge_code
//  m_axis  | out | tdata fields below, one result per request
//  apb     | in  | image_width @0x0, pixel_count @0x4
//
// A merging edge walks and compresses the parent chains of both pixels and
// then merges before m_axis_tvalid rises; a same-region edge skips the merge
// and an out-of-range edge skips the walks. One memory read per cycle sets
// the walk. Reset and each start item run a clearing pass that rewrites one
// row per cycle; a start result waits for the pass to end and the input
// stays closed until the pass ends. The input stalls while a result waits
// on m_axis_tready.
// ----------------------------------------------------------------------------
module kruskal_union_find_tree_builder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [12:0] edge_code
	input  logic        s_axis_tuser,   // kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] merged, [1] bad_edge, [14:2] new_node, [27:15] child_first,
	// [40:28] child_second, [52:41] merge_order
	output logic [55:0] m_axis_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import kuf_pkg::*;

	kuf_cmd_t  cmd;
	kuf_stat_t stat;
	logic [CFG_W-1:0]   width_q, count_q;
	logic [NODE_W-1:0]  nn, cf, cs;
	logic [ORDER_W-1:0] mo;
	logic               mg, bd;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= CFG_W'(64);
			count_q <= CFG_W'(4096);
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_IMAGE_WIDTH) width_q <= pwdata[CFG_W-1:0];
			else                             count_q <= pwdata[CFG_W-1:0];
		end
	end
	assign prdata = {19'd0, (paddr[2] == REG_PIXEL_COUNT) ? count_q : width_q};

	kuf_ctrl u_ctrl (
		.clk, .arst_n,
		.in_fire  (s_axis_tvalid && s_axis_tready),
		.in_kind  (s_axis_tuser),
		.in_ready (s_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.cmd, .stat
	);

	kuf_datapath u_dp (
		.clk, .arst_n, .cmd, .stat,
		.edge_code       (s_axis_tdata[NODE_W-1:0]),
		.image_width     (width_q),
		.pixel_count     (count_q),
		.res_new_node    (nn),
		.res_child_first (cf),
		.res_child_second(cs),
		.res_merge_order (mo),
		.res_merged      (mg),
		.res_bad         (bd)
	);

	assign m_axis_tdata = {3'd0, mo, cs, cf, nn, bd, mg};
endmodule

### tb/sv/kuf_tree_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kuf_tree_checker: result predictor and scoreboard for the tree builder
// Watches the edge, result and register channels, predicts every result
// from its own copy of the union-find state and compares field by field.
// ----------------------------------------------------------------------------
module kuf_tree_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,
	input  logic        s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [55:0] m_axis_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          outstanding,
	output int          mismatches
);
	import kuf_pkg::*;

	typedef struct packed {
		logic [ORDER_W-1:0] merge_order;
		logic [NODE_W-1:0]  child_second;
		logic [NODE_W-1:0]  child_first;
		logic [NODE_W-1:0]  new_node;
		logic               bad_edge;
		logic               merged;
	} tree_result_t;

	tree_result_t pending_results[$];

	int unsigned width_reg;
	int unsigned count_reg;
	int unsigned parent_of[MAX_PIXELS];
	int unsigned rank_of[MAX_PIXELS];
	int unsigned node_of[MAX_PIXELS];
	int unsigned next_node;
	int unsigned edges_merged;

	function automatic int unsigned pixels_in_use();
		return (count_reg < MAX_PIXELS) ? count_reg : MAX_PIXELS;
	endfunction

	function automatic void clear_sets();
		for (int i = 0; i < MAX_PIXELS; i++) begin
			parent_of[i] = i;
			rank_of[i] = 0;
			node_of[i] = i;
		end
		next_node = pixels_in_use() & 32'h1FFF;
		edges_merged = 0;
	endfunction

	// walk to the root, then point every pixel on the chain at it
	function automatic int unsigned root_of(int unsigned p);
		int unsigned r;
		int unsigned nxt;
		r = p;
		while (parent_of[r] != r)
			r = parent_of[r];
		while (parent_of[p] != p) begin
			nxt = parent_of[p];
			parent_of[p] = r;
			p = nxt;
		end
		return r;
	endfunction

	function automatic tree_result_t apply_request(logic kind, logic [12:0] code);
		tree_result_t res;
		int unsigned px, py, rx, ry, lo, hi, n;
		res = '0;
		n = pixels_in_use();
		if (kind == KIND_START) begin
			clear_sets();
			return res;
		end
		px = 32'(code >> 1);
		py = code[0] ? px + width_reg : px + 1;
		if (px >= n || py >= n) begin
			res.bad_edge = 1'b1;
			return res;
		end
		rx = root_of(px);
		ry = root_of(py);
		if (rx == ry)
			return res;
		res.merged = 1'b1;
		res.new_node = NODE_W'(next_node);
		res.child_first = NODE_W'(node_of[rx]);
		res.child_second = NODE_W'(node_of[ry]);
		res.merge_order = ORDER_W'(edges_merged);
		// union by rank, the second root wins a tie
		lo = rx;
		hi = ry;
		if (rank_of[lo] > rank_of[hi]) begin
			lo = ry;
			hi = rx;
		end
		if (rank_of[lo] == rank_of[hi] && rank_of[hi] < 15)
			rank_of[hi]++;
		parent_of[lo] = hi;
		node_of[hi] = next_node;
		next_node = (next_node + 1) & 32'h1FFF;
		edges_merged = (edges_merged + 1) & 32'hFFF;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tree_result_t seen;
		tree_result_t want;
		if (!arst_n) begin
			width_reg = 64;
			count_reg = 4096;
			clear_sets();
			pending_results.delete();
			outstanding <= 0;
			mismatches <= 0;
		end else begin
			// track register writes
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_IMAGE_WIDTH)
					width_reg = 32'(pwdata[12:0]);
				else
					count_reg = 32'(pwdata[12:0]);
			end
			// predict each accepted request
			if (s_axis_tvalid && s_axis_tready)
				pending_results.insert(pending_results.size(),
					apply_request(s_axis_tuser, s_axis_tdata[12:0]));
			// compare each accepted result with the oldest prediction
			if (m_axis_tvalid && m_axis_tready) begin
				seen = m_axis_tdata[52:0];
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result %h", $realtime, seen);
					mismatches <= mismatches + 1;
				end else begin
					want = pending_results.pop_front();
					if (seen.merged !== want.merged ||
					    seen.bad_edge !== want.bad_edge ||
					    seen.new_node !== want.new_node ||
					    seen.child_first !== want.child_first ||
					    seen.child_second !== want.child_second ||
					    seen.merge_order !== want.merge_order ||
					    m_axis_tdata[55:53] !== 3'b000) begin
						$display("%0t: mismatch expected merged=%0d bad=%0d node=%0d c1=%0d c2=%0d ord=%0d",
							$realtime, want.merged, want.bad_edge, want.new_node,
							want.child_first, want.child_second, want.merge_order);
						$display("%0t:          actual   merged=%0d bad=%0d node=%0d c1=%0d c2=%0d ord=%0d",
							$realtime, seen.merged, seen.bad_edge, seen.new_node,
							seen.child_first, seen.child_second, seen.merge_order);
						mismatches <= mismatches + 1;
					end
				end
			end
			outstanding <= pending_results.size();
		end
	end

endmodule

### tb/sv/kruskal_union_find_tree_builder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kruskal_union_find_tree_builder_tb: stimulus and verdict for the builder
// Runs directed edges and random edge streams over several image
// shapes, with random gaps on both streams; the checker judges results.
// ----------------------------------------------------------------------------
module kruskal_union_find_tree_builder_tb;
	import kuf_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;   // [12:0] edge_code
	logic        s_axis_tuser = 1'b0; // kind
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// [0] merged, [1] bad_edge, [14:2] new_node, [27:15] child_first,
	// [40:28] child_second, [52:41] merge_order
	logic [55:0] m_axis_tdata;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	int outstanding;
	int mismatches;
	int idle_cycles = 0;
	bit gaps_on = 1'b1;

	always #5 clk = ~clk;

	kruskal_union_find_tree_builder DUT (.*);

	kuf_tree_checker u_checker (.*);

	function automatic int pick_gap();
		int roll;
		if (!gaps_on)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 50) return 0;
		if (roll < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// random result backpressure
	always @(posedge clk) begin
		if (!gaps_on)
			m_axis_tready <= 1'b1;
		else if ($urandom_range(0, 99) < 3)
			m_axis_tready <= 1'b0;
		else if (!m_axis_tready)
			m_axis_tready <= ($urandom_range(0, 99) < 30);
		else
			m_axis_tready <= ($urandom_range(0, 99) < 80);
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic send_request(logic kind, logic [12:0] code);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {3'b000, code};
		do @(posedge clk); while (!s_axis_tready);
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// drain, let the block settle, then write one register
	task automatic write_reg(logic [0:0] idx, int unsigned value);
		@(posedge clk);
		s_axis_tvalid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic run_image(int unsigned width, int unsigned count, int items);
		int unsigned span;
		int roll;
		write_reg(REG_IMAGE_WIDTH, width);
		write_reg(REG_PIXEL_COUNT, count);
		send_request(KIND_START, 13'($urandom_range(0, 8191)));
		span = (2 * count + 3 > 8191) ? 8191 : 2 * count + 3;
		for (int i = 0; i < items; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 4)
				send_request(KIND_START, 13'($urandom_range(0, 8191)));
			else if (roll < 10)
				send_request(KIND_EDGE, 13'($urandom_range(0, 8191)));
			else
				send_request(KIND_EDGE, 13'($urandom_range(0, span)));
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: default shape, extremes and special cases
		send_request(KIND_EDGE, 13'd0);
		send_request(KIND_EDGE, 13'd1);
		send_request(KIND_EDGE, 13'd2);
		send_request(KIND_EDGE, 13'd0);        // same region
		send_request(KIND_EDGE, 13'd126);      // row end wraps to next row
		send_request(KIND_EDGE, 13'd8190);     // last pixel, neighbor out of range
		send_request(KIND_EDGE, 13'd8191);
		send_request(KIND_EDGE, 13'd8063);     // last valid vertical
		send_request(KIND_START, 13'h1FFF);
		send_request(KIND_EDGE, 13'd3);
		write_reg(REG_IMAGE_WIDTH, 0);         // vertical pair is one pixel
		send_request(KIND_EDGE, 13'd5);
		send_request(KIND_EDGE, 13'd4);
		write_reg(REG_PIXEL_COUNT, 8);         // shrink mid-image
		send_request(KIND_EDGE, 13'd14);
		send_request(KIND_EDGE, 13'd12);
		send_request(KIND_EDGE, 13'd6);
		write_reg(REG_PIXEL_COUNT, 8191);      // above the memory size
		send_request(KIND_EDGE, 13'd8190);
		send_request(KIND_START, 13'd0);
		send_request(KIND_EDGE, 13'd8188);

		// random images of varied shapes
		run_image(4, 16, 90);
		run_image(1, 2, 40);
		run_image(4096, 4096, 60);
		gaps_on = 1'b0;
		run_image(3, 12, 90);
		gaps_on = 1'b1;
		run_image(7, 50, 120);
		run_image(13, 200, 120);
		run_image(0, 30, 40);
		run_image(64, 4096, 100);
		run_image(5, 25, 60);

		@(posedge clk);
		s_axis_tvalid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
